/* rtl/core/assert_macros.svh */
// Assertion macros for the tone sequencer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define PTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen.
`define PTS_ASSERT_NEVER(label, expr, msg) \
  `PTS_ASSERT(label, !(expr), msg)

`endif

/* rtl/core/pts_pkg.sv */
// Package: widths, codes, constants and control structs of the tone sequencer.
`default_nettype none

package pts_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned CLK_W      = 29;
  localparam int unsigned PSC_W      = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 29;
  localparam int unsigned RATE_W     = 13;
  localparam int unsigned HUND_W     = 7;

  localparam int unsigned DEF_TONE_DEPTH = 64;
  localparam int unsigned DEF_VOLUME_MAX = 10;

  localparam logic [FREQ_W-1:0]  FREQ_MIN    = 16'd100;
  localparam logic [FREQ_W-1:0]  FREQ_MAX    = 16'd8000;
  localparam logic [RATE_W-1:0]  SILENT_RATE = 13'd100;
  localparam logic [CLK_W-1:0]   CLK_RESET   = 29'd16000000;
  localparam logic [PSC_W-1:0]   PSC_RESET   = 16'd1;

  // freq / 100 == (freq * RECIP_100) >> RECIP_SHIFT for freq <= 8000
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RECIP_W     = RATE_W + RATE_W;
  localparam logic [RATE_W-1:0] RECIP_100 = 13'd5243;

  // tone index reduction: floor(idx * ceil(2^16 / depth) / 2^16)
  localparam int unsigned IDX_RECIP_SHIFT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_PLAY  = 3'd1,
    CMD_BEEP  = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME = 2'd0,
    CFG_CLOCK  = 2'd1,
    CFG_PSC    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic take;
    logic set_play;
    logic ram_we;
    logic stop;
    logic tick_dec;
    logic tick_off;
    logic adv;
    logic ram_re;
    logic load_tone;
    logic end_seq;
    logic start;
    logic silence;
    logic mul;
    logic cnt;
    logic commit;
    logic set_ok;
    logic emit;
  } pts_cmd_t;

  typedef struct packed {
    logic on;
    logic seq;
    logic cnt_is_one;
    logic tone_end;
    logic tone_silent;
    logic tone_ok;
    logic div_done;
    logic out_free;
  } pts_stat_t;

endpackage

`default_nettype wire

/* rtl/core/pts_ram.sv */
// Generic single-port-write RAM with registered read.
`default_nettype none

module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/pts_div.sv */
// Restoring divider, one quotient bit per cycle, for the timer period.
`default_nettype none

module pts_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pts_pkg::CLK_W-1:0]  dividend_i,
  input  wire logic [pts_pkg::CLK_W-1:0]  divisor_i,
  output logic      [pts_pkg::CLK_W-1:0]  quotient_o,
  output logic                            done_o
);

  localparam int unsigned W    = pts_pkg::CLK_W;
  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic [CntW-1:0] step_q;
  logic [W-1:0]    num_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    den_q;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;

  assign trial = {rem_q, num_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = ~diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + CntW'(1);
      if (step_q == CntW'(W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
      num_q <= {num_q[W-2:0], fits};
    end
  end

  assign quotient_o = num_q;
  assign done_o     = busy_q && (step_q == CntW'(W - 1));

endmodule

`default_nettype wire

/* rtl/core/pts_ctrl.sv */
// Controller: sequences each command through the datapath.
`default_nettype none

module pts_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [pts_pkg::CMD_W-1:0]   command_i,
  input  wire pts_pkg::pts_stat_t          stat_i,
  output logic                             in_stall_o,
  output pts_pkg::pts_cmd_t                cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_WRITE  = 11'b000_0000_0010,
    S_TICK   = 11'b000_0000_0100,
    S_READ   = 11'b000_0000_1000,
    S_LOAD   = 11'b000_0001_0000,
    S_EVAL   = 11'b000_0010_0000,
    S_MUL    = 11'b000_0100_0000,
    S_CNT    = 11'b000_1000_0000,
    S_DIV    = 11'b001_0000_0000,
    S_COMMIT = 11'b010_0000_0000,
    S_FINISH = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   tick_mode_q, tick_mode_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    tick_mode_d = tick_mode_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take  = 1'b1;
          tick_mode_d = 1'b0;
          unique case (command_i)
            pts_pkg::CMD_WRITE: state_d = S_WRITE;
            pts_pkg::CMD_PLAY: begin
              cmd_o.set_play = 1'b1;
              state_d        = S_READ;
            end
            pts_pkg::CMD_BEEP: state_d = S_EVAL;
            pts_pkg::CMD_STOP: begin
              cmd_o.stop = 1'b1;
              state_d    = S_FINISH;
            end
            pts_pkg::CMD_TICK: begin
              tick_mode_d = 1'b1;
              state_d     = S_TICK;
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.ram_we = 1'b1;
        state_d      = S_FINISH;
      end
      S_TICK: begin
        state_d = S_FINISH;
        if (stat_i.on) begin
          cmd_o.tick_dec = 1'b1;
          if (stat_i.cnt_is_one) begin
            if (stat_i.seq) begin
              cmd_o.adv = 1'b1;
              state_d   = S_READ;
            end else begin
              cmd_o.tick_off = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        cmd_o.ram_re = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_tone = 1'b1;
        state_d         = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_FINISH;
        if (tick_mode_q && stat_i.tone_end) begin
          cmd_o.end_seq = 1'b1;
        end else if (tick_mode_q && stat_i.tone_silent) begin
          cmd_o.silence = 1'b1;
          state_d       = S_MUL;
        end else if (stat_i.tone_ok) begin
          cmd_o.start = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CNT;
      end
      S_CNT: begin
        cmd_o.cnt = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.set_ok = ~tick_mode_q;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_mode_q <= tick_mode_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pts_dp.sv */
// Datapath: config registers, tone memory, timer math and result register.
`default_nettype none

module pts_dp #(
  parameter int unsigned TONE_DEPTH = pts_pkg::DEF_TONE_DEPTH,
  parameter int unsigned VOLUME_MAX = pts_pkg::DEF_VOLUME_MAX
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pts_pkg::pts_cmd_t                cmd_i,
  output pts_pkg::pts_stat_t                    stat_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [pts_pkg::IDX_W-1:0]        tone_index_i,
  input  wire logic [pts_pkg::FREQ_W-1:0]       frequency_i,
  input  wire logic [pts_pkg::DUR_W-1:0]        duration_i,
  input  wire logic                             out_stall_i,
  output logic                                  out_valid_o,
  output logic                                  pwm_enabled_o,
  output logic      [pts_pkg::DATA_W-1:0]       pwm_period_o,
  output logic      [pts_pkg::DATA_W-1:0]       pwm_compare_o,
  output logic                                  playing_o,
  output logic                                  accepted_o
);

  localparam int unsigned IdxW      = pts_pkg::IDX_W;
  localparam int unsigned PosW      = $clog2(TONE_DEPTH);
  localparam int unsigned DW        = pts_pkg::DATA_W;
  localparam int unsigned FW        = pts_pkg::FREQ_W;
  localparam int unsigned LW        = pts_pkg::DUR_W;
  localparam int unsigned CW        = pts_pkg::CLK_W;
  localparam int unsigned RamW      = FW + LW;
  localparam int unsigned IdxProdW  = IdxW + pts_pkg::IDX_RECIP_SHIFT;
  localparam int unsigned IdxRecip  =
    (2 ** pts_pkg::IDX_RECIP_SHIFT + TONE_DEPTH - 1) / TONE_DEPTH;
  localparam int unsigned IdxBackW  = IdxW + $clog2(TONE_DEPTH + 1);
  localparam logic [5:0]  ShiftBase = 6'(VOLUME_MAX + 1);
  localparam logic [4:0]  VolMax    = 5'(VOLUME_MAX);

  // config
  logic [pts_pkg::VOL_W-1:0] vol_q;
  logic [CW-1:0]             clk_hz_q;
  logic [pts_pkg::PSC_W-1:0] psc_q;
  logic [pts_pkg::PSC_W-1:0] psc_eff;

  // architectural state
  logic [PosW-1:0] pos_q;
  logic            seq_q;
  logic            on_q;
  logic [DW-1:0]   count_q;
  logic [DW-1:0]   period_q;
  logic [DW-1:0]   compare_q;

  // work registers
  logic [PosW-1:0]                 idx_q;
  logic [FW-1:0]                   tf_q;
  logic [LW-1:0]                   td_q;
  logic [pts_pkg::RATE_W-1:0]      rate_q;
  logic                            silent_q;
  logic [CW-1:0]                   prod_q;
  logic [pts_pkg::RECIP_W-1:0]     recip_q;
  logic [DW-1:0]                   load_q;
  logic                            ok_q;

  // result register
  logic          out_valid_q;
  logic          out_en_q;
  logic [DW-1:0] out_period_q;
  logic [DW-1:0] out_compare_q;
  logic          out_play_q;
  logic          out_ok_q;

  logic [IdxProdW-1:0]       idx_prod;
  logic [IdxW-1:0]           idx_quo;
  logic [IdxBackW-1:0]       idx_back;
  logic [IdxW-1:0]           idx_rem;
  logic [PosW-1:0]           idx_mod;
  logic [PosW-1:0]           pos_next;
  logic [RamW-1:0]           ram_rdata;
  logic [CW-1:0]             quot;
  logic                      div_done;
  logic [pts_pkg::HUND_W-1:0] hundreds;
  logic [DW-1:0]             period_d;
  logic [5:0]                shift_amt;
  logic [DW-1:0]             cmp_d;
  logic                      out_free;

  // tone index modulo depth
  assign idx_prod = IdxProdW'(tone_index_i) * IdxProdW'(IdxRecip);
  assign idx_quo  = idx_prod[IdxProdW-1 -: IdxW];
  assign idx_back = IdxBackW'(idx_quo) * IdxBackW'(TONE_DEPTH);
  assign idx_rem  = tone_index_i - idx_back[IdxW-1:0];
  assign idx_mod  = PosW'(idx_rem);

  assign pos_next = (pos_q == PosW'(TONE_DEPTH - 1)) ? '0 : pos_q + PosW'(1);
  assign psc_eff  = (psc_q == '0) ? pts_pkg::PSC_RESET : psc_q;
  assign hundreds = pts_pkg::HUND_W'(recip_q >> pts_pkg::RECIP_SHIFT);

  assign period_d  = DW'(quot) - DW'(1);
  assign shift_amt = ShiftBase - {2'b00, vol_q};
  assign cmp_d     = (shift_amt >= 6'(DW)) ? '0 : (period_d >> shift_amt[4:0]);

  assign out_free  = ~out_valid_q | ~out_stall_i;

  pts_ram #(
    .WIDTH (RamW),
    .DEPTH (TONE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (idx_q),
    .wdata_i ({tf_q, td_q}),
    .re_i    (cmd_i.ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  pts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cnt),
    .dividend_i (clk_hz_q),
    .divisor_i  (prod_q),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q    <= '0;
      clk_hz_q <= pts_pkg::CLK_RESET;
      psc_q    <= pts_pkg::PSC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pts_pkg::CFG_VOLUME: begin
          vol_q <= ({1'b0, cfg_data_i[3:0]} > VolMax) ? VolMax[3:0] : cfg_data_i[3:0];
        end
        pts_pkg::CFG_CLOCK: clk_hz_q <= cfg_data_i;
        pts_pkg::CFG_PSC:   psc_q    <= cfg_data_i[pts_pkg::PSC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      seq_q     <= 1'b0;
      on_q      <= 1'b0;
      count_q   <= '0;
      period_q  <= '0;
      compare_q <= '0;
    end else begin
      if (cmd_i.set_play) begin
        pos_q <= idx_mod;
        seq_q <= 1'b1;
      end
      if (cmd_i.stop || cmd_i.end_seq) begin
        on_q  <= 1'b0;
        seq_q <= 1'b0;
        pos_q <= '0;
      end
      if (cmd_i.tick_dec) begin
        count_q <= count_q - DW'(1);
      end
      if (cmd_i.tick_off) begin
        on_q <= 1'b0;
      end
      if (cmd_i.adv) begin
        pos_q <= pos_next;
      end
      if (cmd_i.commit) begin
        period_q  <= period_d;
        compare_q <= silent_q ? '0 : cmp_d;
        count_q   <= load_q;
        if (!silent_q) begin
          on_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_q <= idx_mod;
      tf_q  <= frequency_i;
      td_q  <= duration_i;
      ok_q  <= 1'b0;
    end
    if (cmd_i.load_tone) begin
      tf_q <= ram_rdata[RamW-1 -: FW];
      td_q <= ram_rdata[LW-1:0];
    end
    if (cmd_i.start) begin
      rate_q   <= tf_q[pts_pkg::RATE_W-1:0];
      silent_q <= 1'b0;
    end
    if (cmd_i.silence) begin
      rate_q   <= pts_pkg::SILENT_RATE;
      silent_q <= 1'b1;
    end
    if (cmd_i.mul) begin
      prod_q  <= CW'(rate_q) * CW'(psc_eff);
      recip_q <= pts_pkg::RECIP_W'(tf_q[pts_pkg::RATE_W-1:0]) *
                 pts_pkg::RECIP_W'(pts_pkg::RECIP_100);
    end
    if (cmd_i.cnt) begin
      load_q <= silent_q ? (DW'(td_q) + DW'(1))
                         : (DW'(hundreds) * DW'(td_q) + DW'(1));
    end
    if (cmd_i.commit) begin
      ok_q <= cmd_i.set_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_en_q      <= on_q;
      out_period_q  <= period_q;
      out_compare_q <= compare_q;
      out_play_q    <= seq_q;
      out_ok_q      <= ok_q;
    end
  end

  assign stat_o.on          = on_q;
  assign stat_o.seq         = seq_q;
  assign stat_o.cnt_is_one  = (count_q == DW'(1));
  assign stat_o.tone_end    = (tf_q == '0) && (td_q == '0);
  assign stat_o.tone_silent = (tf_q == '0);
  assign stat_o.tone_ok     = (tf_q >= pts_pkg::FREQ_MIN) && (tf_q <= pts_pkg::FREQ_MAX) &&
                              (td_q != '0);
  assign stat_o.div_done    = div_done;
  assign stat_o.out_free    = out_free;

  assign out_valid_o   = out_valid_q;
  assign pwm_enabled_o = out_en_q;
  assign pwm_period_o  = out_period_q;
  assign pwm_compare_o = out_compare_q;
  assign playing_o     = out_play_q;
  assign accepted_o    = out_ok_q;

endmodule

`default_nettype wire

/* rtl/core/pwm_tone_sequencer_unit.sv */
// Top level: buzzer PWM tone sequencer, controller plus datapath.
//
//   Port group   Handshake               Carries
//   cfg          cfg_we_i                cfg_index_i, cfg_data_i
//   in           in_valid_i / in_stall_o command, tone index, frequency, duration
//   out          out_valid_o/ out_stall_i pwm state, period, compare, playing, accepted
//
// One beat at a time. Stop and unused codes go straight to the finish state; a write and a
// tick that loads nothing pass the write or tick state. Invalid tones and end entries stop at
// evaluate. A beat that loads a tone runs multiply, count, 29-step period divider and commit.
// The next beat is taken while a finished result waits in the output register.
// A stalled result holds the following beat in its finish state.
// Reset is asynchronous, active low; the tone memory is not cleared.
`default_nettype none

module pwm_tone_sequencer_unit #(
  parameter int unsigned TONE_DEPTH = pts_pkg::DEF_TONE_DEPTH,
  parameter int unsigned VOLUME_MAX = pts_pkg::DEF_VOLUME_MAX
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [pts_pkg::CMD_W-1:0]        command_i,
  input  wire logic [pts_pkg::IDX_W-1:0]        tone_index_i,
  input  wire logic [pts_pkg::FREQ_W-1:0]       frequency_i,
  input  wire logic [pts_pkg::DUR_W-1:0]        duration_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  pwm_enabled_o,
  output logic      [pts_pkg::DATA_W-1:0]       pwm_period_o,
  output logic      [pts_pkg::DATA_W-1:0]       pwm_compare_o,
  output logic                                  playing_o,
  output logic                                  accepted_o
);

  pts_pkg::pts_cmd_t  cmd;
  pts_pkg::pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pts_dp #(
    .TONE_DEPTH (TONE_DEPTH),
    .VOLUME_MAX (VOLUME_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .tone_index_i  (tone_index_i),
    .frequency_i   (frequency_i),
    .duration_i    (duration_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .pwm_enabled_o (pwm_enabled_o),
    .pwm_period_o  (pwm_period_o),
    .pwm_compare_o (pwm_compare_o),
    .playing_o     (playing_o),
    .accepted_o    (accepted_o)
  );

endmodule

`default_nettype wire

/* rtl/core/pts_chk.sv */
// Port-level checker for the tone sequencer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pts_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic                             pwm_enabled_o,
  input wire logic [pts_pkg::DATA_W-1:0]       pwm_period_o,
  input wire logic [pts_pkg::DATA_W-1:0]       pwm_compare_o,
  input wire logic                             accepted_o
);

  logic                            out_held;
  logic [2*pts_pkg::DATA_W+1:0]    out_fields;

  assign out_held   = out_valid_o && out_stall_i;
  assign out_fields = {pwm_enabled_o, pwm_period_o, pwm_compare_o, accepted_o};

  // one beat in work at a time
  `PTS_ASSERT(a_busy_after_beat, in_valid_i && !in_stall_o |=> in_stall_o, "busy after beat")

  // duty compare is the period shifted down, or zero
  `PTS_ASSERT(a_cmp_le_period, out_valid_o |-> pwm_compare_o <= pwm_period_o, "duty too big")

  `PTS_ASSERT_NEVER(a_ok_needs_pwm, out_valid_o && accepted_o && !pwm_enabled_o, "ok, pwm off")

  `PTS_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_fields), "result changed")

endmodule

bind pwm_tone_sequencer_unit pts_chk u_pts_chk (.*);

`default_nettype wire

/* bench/pts_tone_checker.sv */
// Tone sequencer checker: watches both channels, predicts each result beat and compares it.
`timescale 1ns / 100ps

module pts_tone_checker #(
  parameter int unsigned TONE_DEPTH = pts_pkg::DEF_TONE_DEPTH,
  parameter int unsigned VOLUME_MAX = pts_pkg::DEF_VOLUME_MAX
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [pts_pkg::CMD_W-1:0]      command_i,
  input  logic [pts_pkg::IDX_W-1:0]      tone_index_i,
  input  logic [pts_pkg::FREQ_W-1:0]     frequency_i,
  input  logic [pts_pkg::DUR_W-1:0]      duration_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           pwm_enabled_i,
  input  logic [pts_pkg::DATA_W-1:0]     pwm_period_i,
  input  logic [pts_pkg::DATA_W-1:0]     pwm_compare_i,
  input  logic                           playing_i,
  input  logic                           accepted_i,
  output int                             mismatches_o,
  output int                             pending_o
);
  import pts_pkg::*;

  typedef struct packed {
    logic              enabled;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] compare;
    logic              playing;
    logic              accepted;
  } pwm_status_t;

  logic [FREQ_W-1:0] freq_mem [TONE_DEPTH];
  logic [DUR_W-1:0]  len_mem  [TONE_DEPTH];
  logic [DATA_W-1:0] ticks_left;
  logic [DATA_W-1:0] reload;
  logic [DATA_W-1:0] duty;
  int unsigned       cursor;
  logic              seq_on;
  logic              pwm_on;
  logic [VOL_W-1:0]  vol;
  logic [CLK_W-1:0]  core_hz;
  logic [PSC_W-1:0]  psc;
  int                fails = 0;
  pwm_status_t       status_q[$];

  initial begin
    mismatches_o <= 0;
    pending_o    <= 0;
  end

  function automatic logic [DATA_W-1:0] timer_reload(input logic [RATE_W-1:0] rate);
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] hz;
    r  = DATA_W'(rate);
    p  = (psc == '0) ? DATA_W'(1) : DATA_W'(psc);
    hz = DATA_W'(core_hz);
    return hz / (r * p) - DATA_W'(1);
  endfunction

  task automatic start_tone(input logic [FREQ_W-1:0] f, input logic [DUR_W-1:0] d,
                            output logic ok);
    logic [DATA_W-1:0] units;
    logic [DATA_W-1:0] len;
    int unsigned       shift;
    ok = 1'b0;
    if (f >= FREQ_MIN && f <= FREQ_MAX && d != '0) begin
      units      = DATA_W'(f / 16'd100);
      len        = DATA_W'(d);
      ticks_left = units * len + DATA_W'(1);
      reload     = timer_reload(f[RATE_W-1:0]);
      shift      = VOLUME_MAX + 1 - 32'(vol);
      duty       = (shift >= 32) ? '0 : (reload >> shift);
      pwm_on     = 1'b1;
      ok         = 1'b1;
    end
  endtask

  task automatic tick_once();
    logic [FREQ_W-1:0] nf;
    logic [DUR_W-1:0]  nd;
    logic [DATA_W-1:0] len;
    logic              ok;
    if (pwm_on) begin
      ticks_left = ticks_left - DATA_W'(1);
      if (ticks_left == '0) begin
        if (!seq_on) begin
          pwm_on = 1'b0;
        end else begin
          cursor = (cursor + 1) % TONE_DEPTH;
          nf     = freq_mem[cursor];
          nd     = len_mem[cursor];
          if (nf == '0 && nd == '0) begin
            pwm_on = 1'b0;
            seq_on = 1'b0;
            cursor = 0;
          end else if (nf == '0) begin
            // silent entry: 100 Hz period, zero duty
            reload     = timer_reload(SILENT_RATE);
            duty       = '0;
            len        = DATA_W'(nd);
            ticks_left = len + DATA_W'(1);
          end else begin
            start_tone(nf, nd, ok);
          end
        end
      end
    end
  endtask

  task automatic apply_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [FREQ_W-1:0] f, input logic [DUR_W-1:0] d,
                            output pwm_status_t res);
    logic        ok;
    int unsigned slot;
    ok   = 1'b0;
    slot = 32'(idx) % TONE_DEPTH;
    case (cmd)
      CMD_WRITE: begin
        freq_mem[slot] = f;
        len_mem[slot]  = d;
      end
      CMD_PLAY: begin
        cursor = slot;
        seq_on = 1'b1;
        start_tone(freq_mem[slot], len_mem[slot], ok);
      end
      CMD_BEEP: start_tone(f, d, ok);
      CMD_STOP: begin
        pwm_on = 1'b0;
        seq_on = 1'b0;
        cursor = 0;
      end
      CMD_TICK: tick_once();
      default: ;
    endcase
    res = '{pwm_on, reload, duty, seq_on, ok};
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    pwm_status_t want;
    if (!rst_ni) begin
      ticks_left = '0;
      reload     = '0;
      duty       = '0;
      cursor     = 0;
      seq_on     = 1'b0;
      pwm_on     = 1'b0;
      vol        = '0;
      core_hz    = CLK_RESET;
      psc        = PSC_RESET;
      status_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got period 0x%0h compare 0x%0h",
                   $time, pwm_period_i, pwm_compare_i);
          fails++;
        end else begin
          want = status_q.pop_front();
          check_field("pwm_enabled", DATA_W'(want.enabled), DATA_W'(pwm_enabled_i));
          check_field("pwm_period", want.period, pwm_period_i);
          check_field("pwm_compare", want.compare, pwm_compare_i);
          check_field("playing", DATA_W'(want.playing), DATA_W'(playing_i));
          check_field("accepted", DATA_W'(want.accepted), DATA_W'(accepted_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_VOLUME: begin
            if (32'(cfg_data_i[VOL_W-1:0]) > VOLUME_MAX) vol = VOL_W'(VOLUME_MAX);
            else vol = cfg_data_i[VOL_W-1:0];
          end
          CFG_CLOCK: core_hz = cfg_data_i[CLK_W-1:0];
          CFG_PSC:   psc = cfg_data_i[PSC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        apply_beat(command_i, tone_index_i, frequency_i, duration_i, want);
        status_q.push_back(want);
      end
    end
    pending_o    <= status_q.size();
    mismatches_o <= fails;
  end

endmodule

/* bench/tb_pwm_tone_sequencer_unit.sv */
// Testbench top for the tone sequencer: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 100ps

module tb_pwm_tone_sequencer_unit;
  import pts_pkg::*;

  localparam int BEATS_PER_SETTING = 230;
  localparam int SETTLE_CYCLES     = 48;
  localparam int WATCHDOG_LIMIT    = 2000;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = CFG_VOLUME;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic [CMD_W-1:0]      command_i    = CMD_STOP;
  logic [IDX_W-1:0]      tone_index_i = '0;
  logic [FREQ_W-1:0]     frequency_i  = '0;
  logic [DUR_W-1:0]      duration_i   = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  pwm_enabled_o;
  logic [DATA_W-1:0]     pwm_period_o;
  logic [DATA_W-1:0]     pwm_compare_o;
  logic                  playing_o;
  logic                  accepted_o;

  int mismatches;
  int pending;
  int beats_sent    = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;
  int src_idle_pct  = 0;
  int dst_stall_pct = 0;

  pwm_tone_sequencer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .command_i, .tone_index_i, .frequency_i, .duration_i,
    .out_valid_o, .out_stall_i, .pwm_enabled_o, .pwm_period_o, .pwm_compare_o,
    .playing_o, .accepted_o
  );

  pts_tone_checker tone_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .tone_index_i, .frequency_i,
    .duration_i, .out_valid_i(out_valid_o), .out_stall_i,
    .pwm_enabled_i(pwm_enabled_o), .pwm_period_i(pwm_period_o),
    .pwm_compare_i(pwm_compare_o), .playing_i(playing_o), .accepted_i(accepted_o),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < dst_stall_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // returns at the edge that takes the beat; valid stays up until the next call decides
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [FREQ_W-1:0] f, input logic [DUR_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    tone_index_i <= idx;
    frequency_i  <= f;
    duration_i   <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd <= CMD_TICK) beats_sent++;
  endtask

  task automatic send_noise_fields(input logic [CMD_W-1:0] cmd);
    send_beat(cmd, 6'($urandom), 16'($urandom), 24'($urandom));
  endtask

  // mostly short tones so sequences advance within a few ticks
  task automatic pick_entry(output logic [FREQ_W-1:0] f, output logic [DUR_W-1:0] d);
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      f = FREQ_W'($urandom_range(100, 399));
      d = DUR_W'($urandom_range(1, 3));
    end else if (r < 60) begin
      f = FREQ_W'($urandom_range(100, 8000));
      d = 24'd1;
    end else if (r < 72) begin
      f = '0;
      d = DUR_W'($urandom_range(1, 5));
    end else if (r < 82) begin
      f = '0;
      d = '0;
    end else if (r < 92) begin
      case ($urandom_range(2))
        0: f = FREQ_W'($urandom_range(1, 99));
        1: f = FREQ_W'($urandom_range(8001, 65535));
        default: f = FREQ_W'($urandom_range(100, 8000));
      endcase
      d = (f >= FREQ_MIN && f <= FREQ_MAX) ? 24'd0 : 24'($urandom);
    end else begin
      f = 16'($urandom);
      d = 24'($urandom);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  task automatic apply_setting(input int k);
    logic [CFG_DATA_W-1:0] v;
    logic [CFG_DATA_W-1:0] c;
    logic [CFG_DATA_W-1:0] p;
    v = CFG_DATA_W'($urandom);
    c = CFG_DATA_W'($urandom_range(1, 29'h1FFF_FFFF));
    p = CFG_DATA_W'($urandom);
    case (k)
      1: begin
        v[VOL_W-1:0] = 4'd10;
        c            = '1;
        p[PSC_W-1:0] = 16'hFFFF;
      end
      2: begin
        v[VOL_W-1:0] = 4'hF;   // above max, clamps
        c            = CFG_DATA_W'(1);
        p[PSC_W-1:0] = 16'h0;  // zero prescaler acts as one
      end
      4: begin
        v[VOL_W-1:0] = 4'd0;
        c            = CFG_DATA_W'(48_000_000);
        p[PSC_W-1:0] = 16'd3;
      end
      default: ;
    endcase
    wait_drained();
    cfg_write(CFG_VOLUME, v);
    cfg_write(CFG_CLOCK, c);
    cfg_write(CFG_PSC, p);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_and_directed();
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    // every entry gets written before any play can reach it
    for (int i = 0; i < DEF_TONE_DEPTH; i++) begin
      pick_entry(f, d);
      case (i)
        62: begin f = 16'd200;  d = 24'd1; end
        63: begin f = 16'd0;    d = 24'd2; end
        0:  begin f = 16'd150;  d = 24'd1; end
        1:  begin f = 16'd0;    d = 24'd0; end
        4:  begin f = 16'd100;  d = 24'd1; end
        5:  begin f = 16'd9000; d = 24'd4; end
        default: ;
      endcase
      send_beat(CMD_WRITE, IDX_W'(i), f, d);
    end
    send_beat(CMD_BEEP, 6'd0, 16'd100, 24'd1);
    repeat (3) send_beat(CMD_TICK, 6'd0, 16'd0, 24'd0);  // last one lands with pwm off
    send_beat(CMD_BEEP, 6'd63, 16'd8000, 24'hFF_FFFF);
    send_beat(CMD_BEEP, 6'd0, 16'd99, 24'd5);
    send_beat(CMD_BEEP, 6'd0, 16'd8001, 24'd5);
    send_beat(CMD_BEEP, 6'd0, 16'd500, 24'd0);
    send_beat(CMD_BEEP, 6'd63, 16'hFFFF, 24'hFF_FFFF);
    send_beat(CMD_STOP, 6'd0, 16'd0, 24'd0);
    for (int c = CMD_TICK + 1; c < (1 << CMD_W); c++) begin
      send_beat(CMD_W'(c), 6'd63, 16'hFFFF, 24'hFF_FFFF);
    end
    // tone, silence, wrap to entry 0, end marker
    send_beat(CMD_PLAY, 6'd62, 16'd0, 24'd0);
    repeat (8) send_beat(CMD_TICK, 6'd0, 16'd0, 24'd0);
    // tone into an invalid entry: countdown wraps
    send_beat(CMD_PLAY, 6'd4, 16'd0, 24'd0);
    repeat (3) send_beat(CMD_TICK, 6'd0, 16'd0, 24'd0);
    send_beat(CMD_PLAY, 6'd5, 16'd0, 24'd0);
    send_beat(CMD_STOP, 6'd0, 16'd0, 24'd0);
  endtask

  task automatic play_session();
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    repeat ($urandom_range(3)) begin
      pick_entry(f, d);
      send_beat(CMD_WRITE, 6'($urandom), f, d);
    end
    if ($urandom_range(3) == 0) begin
      pick_entry(f, d);
      send_beat(CMD_BEEP, 6'($urandom), f, d);
    end else begin
      send_noise_fields(CMD_PLAY);
    end
    repeat ($urandom_range(2, 30)) send_noise_fields(CMD_TICK);
    if ($urandom_range(1) == 1) send_noise_fields(CMD_STOP);
  endtask

  task automatic run_random(input int target);
    int start;
    start = beats_sent;
    while (beats_sent - start < target) begin
      if ($urandom_range(99) < 75) play_session();
      else send_noise_fields(3'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < 6; k++) begin
      case (k / 2)
        0: begin src_idle_pct = 35; dst_stall_pct = 69; end
        1: begin src_idle_pct = 69; dst_stall_pct = 35; end
        default: begin src_idle_pct = 0; dst_stall_pct = 0; end
      endcase
      if (k == 0) fill_and_directed();
      else apply_setting(k);
      run_random(BEATS_PER_SETTING);
    end
    wait_drained();
    $display("Run covered %0d command beats over three stall mixes and six register settings,",
             beats_sent);
    $display("with %0d register writes including clamped volume and zero prescaler.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pts_pkg.sv
rtl/core/pts_ram.sv
rtl/core/pts_div.sv
rtl/core/pts_ctrl.sv
rtl/core/pts_dp.sv
rtl/core/pwm_tone_sequencer_unit.sv
rtl/core/pts_chk.sv
bench/pts_tone_checker.sv
bench/tb_pwm_tone_sequencer_unit.sv
